// ===== hdl/periodic_view_box_particle_cull_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the periodic view-box particle cull unit
// Concurrent checks clocked on clk; the plain form is disabled during rst.
// ---------------------------------------------------------------------------
`ifndef PERIODIC_VIEW_BOX_PARTICLE_CULL_UNIT_DEFINES_SVH
`define PERIODIC_VIEW_BOX_PARTICLE_CULL_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PVBC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pvbc: property failed");
`define PVBC_ASSERT_RESET(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("pvbc: reset property failed");
`else
`define PVBC_ASSERT(lbl, prop)
`define PVBC_ASSERT_RESET(lbl, prop)
`endif
`endif

// ===== hdl/pvbc_pkg.sv =====
// ---------------------------------------------------------------------------
// Particle cull package
// Fixed field widths, register indices and shared types.
// ---------------------------------------------------------------------------
package pvbc_pkg;

  localparam int AXIS_W      = 16;
  localparam int BOUND_W     = 32;
  localparam int BOX_W       = 20;
  localparam int FILL_W      = 24;
  localparam int AXIS_REG_W  = 3 * AXIS_W;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 3;

  // bounds and box are scaled into the unit of the projection
  localparam int SHIFT_LIN = 14;
  localparam int SHIFT_UP  = 28;

  localparam logic [CFG_INDEX_W-1:0] REG_CAMERA_POSITION = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RIGHT_AXIS      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_VIEW_AXIS       = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BOUNDS_RIGHT    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_BOUNDS_UP       = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_BOUNDS_VIEW     = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_BOX_SIZE        = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_FILL_DIVISOR    = 3'd7;

  typedef struct packed {
    logic [BOUND_W-1:0] hi;
    logic [BOUND_W-1:0] lo;
  } bounds_t;

  typedef logic signed [AXIS_W-1:0] axis_comp_t;

endpackage

// ===== hdl/pvbc_channels.sv =====
// ---------------------------------------------------------------------------
// Particle cull channels
// Valid/ready stream carrying particle positions in and cull results out.
// ---------------------------------------------------------------------------
interface pvbc_particle_if #(
  parameter int COORD_WIDTH = 21
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] pos_x;
  logic signed [COORD_WIDTH-1:0] pos_y;
  logic signed [COORD_WIDTH-1:0] pos_z;
  logic                          end_of_pass;

  modport source (output valid, pos_x, pos_y, pos_z, end_of_pass, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, end_of_pass, output ready);
endinterface

interface pvbc_result_if #(
  parameter int INDEX_WIDTH = 24
);
  logic                   valid;
  logic                   ready;
  logic                   keep;
  logic [INDEX_WIDTH-1:0] particle_index;
  logic [INDEX_WIDTH:0]   kept_count;

  modport source (output valid, keep, particle_index, kept_count, input ready);
  modport sink   (input valid, keep, particle_index, kept_count, output ready);
endinterface

// ===== hdl/periodic_view_box_particle_cull_unit.sv =====
// ---------------------------------------------------------------------------
// Periodic view-box particle cull unit
// Particles arrive one beat each on the particle channel (x, y, z and an
// end_of_pass mark) and leave as one result beat each on the result channel:
// keep flag, index within the pass and running count of kept particles.
// Settings are written through cfg_write/cfg_index/cfg_data, with register
// indices from the package constants; the user must write only while no
// particle is in flight, as the block itself does not enforce it.
// Six-stage pipeline: offset, axis products, projection sums, up-axis
// products, up sum, then bound tests and counters into the result register.
// One particle is accepted every cycle while particle.ready is high. The
// multiplier chain (offset times the cross-product up axis) sets the depth.
// The whole pipeline advances when the result register is empty or taken;
// while the receiver stalls a waiting result beat, particle.ready falls and
// all stages hold, empty ones included. Reset clears settings to zero,
// empties the pipeline and restarts the index, fill and kept counters.
// ---------------------------------------------------------------------------
`include "periodic_view_box_particle_cull_unit_defines.svh"

module periodic_view_box_particle_cull_unit #(
  parameter int INDEX_WIDTH = 24,
  parameter int COORD_WIDTH = 21
) (
  input  logic                                clk,
  input  logic                                rst,
  pvbc_particle_if.sink                       particle,
  pvbc_result_if.source                       result,
  input  logic                                cfg_write,
  input  logic [pvbc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [pvbc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import pvbc_pkg::*;

  localparam int CAM_W  = 3 * COORD_WIDTH;
  localparam int V_W    = COORD_WIDTH + 1;
  localparam int RP_W   = V_W + AXIS_W;
  localparam int PROJ_W = RP_W + 2;
  localparam int RW_W   = 2 * AXIS_W;
  localparam int U_W    = RW_W + 1;
  localparam int Q_W    = V_W + U_W;
  localparam int PU_W   = Q_W + 2;
  localparam int PH_W   = ((INDEX_WIDTH > FILL_W) ? INDEX_WIDTH : FILL_W) + 1;

  // settings
  logic [CAM_W-1:0]      camera_position;
  logic [AXIS_REG_W-1:0] right_axis;
  logic [AXIS_REG_W-1:0] view_axis;
  bounds_t               bounds_right;
  bounds_t               bounds_up;
  bounds_t               bounds_view;
  logic [BOX_W-1:0]      box_size;
  logic [FILL_W-1:0]     fill_divisor;

  always_ff @(posedge clk) begin
    if (rst) begin
      camera_position <= '0;
      right_axis      <= '0;
      view_axis       <= '0;
      bounds_right    <= '0;
      bounds_up       <= '0;
      bounds_view     <= '0;
      box_size        <= '0;
      fill_divisor    <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CAMERA_POSITION: camera_position <= cfg_data[CAM_W-1:0];
        REG_RIGHT_AXIS:      right_axis      <= cfg_data[AXIS_REG_W-1:0];
        REG_VIEW_AXIS:       view_axis       <= cfg_data[AXIS_REG_W-1:0];
        REG_BOUNDS_RIGHT:    bounds_right    <= bounds_t'(cfg_data);
        REG_BOUNDS_UP:       bounds_up       <= bounds_t'(cfg_data);
        REG_BOUNDS_VIEW:     bounds_view     <= bounds_t'(cfg_data);
        REG_BOX_SIZE:        box_size        <= cfg_data[BOX_W-1:0];
        REG_FILL_DIVISOR:    fill_divisor    <= cfg_data[FILL_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic advance;
  logic s1_valid, s2_valid, s3_valid, s4_valid, s5_valid, out_valid;

  assign advance        = !out_valid || result.ready;
  assign particle.ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      s5_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= particle.valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      s5_valid  <= s4_valid;
      out_valid <= s5_valid;
    end
  end

  // unpacked settings
  logic signed [COORD_WIDTH-1:0] pos_in [3];
  logic signed [COORD_WIDTH-1:0] cam_c  [3];
  axis_comp_t                    r_c    [3];
  axis_comp_t                    w_c    [3];

  always_comb begin
    pos_in[0] = particle.pos_x;
    pos_in[1] = particle.pos_y;
    pos_in[2] = particle.pos_z;
    for (int k = 0; k < 3; k++) begin
      cam_c[k] = $signed(camera_position[k*COORD_WIDTH +: COORD_WIDTH]);
      r_c[k]   = $signed(right_axis[k*AXIS_W +: AXIS_W]);
      w_c[k]   = $signed(view_axis[k*AXIS_W +: AXIS_W]);
    end
  end

  // stage 1: offset from camera
  logic signed [V_W-1:0] s1_v [3];
  logic                  s1_eop;

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int k = 0; k < 3; k++) begin
        s1_v[k] <= V_W'(pos_in[k]) - V_W'(cam_c[k]);
      end
      s1_eop <= particle.end_of_pass;
    end
  end

  // stage 2: right/view products and cross-product terms
  logic signed [RP_W-1:0] s2_pr [3];
  logic signed [RP_W-1:0] s2_pv [3];
  logic signed [RW_W-1:0] s2_rw [6];
  logic signed [V_W-1:0]  s2_v  [3];
  logic                   s2_eop;

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int k = 0; k < 3; k++) begin
        s2_pr[k] <= s1_v[k] * r_c[k];
        s2_pv[k] <= s1_v[k] * w_c[k];
        s2_v[k]  <= s1_v[k];
      end
      s2_rw[0] <= r_c[1] * w_c[2];
      s2_rw[1] <= r_c[2] * w_c[1];
      s2_rw[2] <= r_c[2] * w_c[0];
      s2_rw[3] <= r_c[0] * w_c[2];
      s2_rw[4] <= r_c[0] * w_c[1];
      s2_rw[5] <= r_c[1] * w_c[0];
      s2_eop   <= s1_eop;
    end
  end

  // stage 3: right/view sums and up axis
  logic signed [PROJ_W-1:0] s3_pr;
  logic signed [PROJ_W-1:0] s3_pv;
  logic signed [U_W-1:0]    s3_u [3];
  logic signed [V_W-1:0]    s3_v [3];
  logic                     s3_eop;

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_pr   <= PROJ_W'(s2_pr[0]) + PROJ_W'(s2_pr[1]) + PROJ_W'(s2_pr[2]);
      s3_pv   <= PROJ_W'(s2_pv[0]) + PROJ_W'(s2_pv[1]) + PROJ_W'(s2_pv[2]);
      s3_u[0] <= U_W'(s2_rw[0]) - U_W'(s2_rw[1]);
      s3_u[1] <= U_W'(s2_rw[2]) - U_W'(s2_rw[3]);
      s3_u[2] <= U_W'(s2_rw[4]) - U_W'(s2_rw[5]);
      for (int k = 0; k < 3; k++) begin
        s3_v[k] <= s2_v[k];
      end
      s3_eop <= s2_eop;
    end
  end

  // stage 4: up products, right/view bound tests
  logic                  hit_r, hit_v;
  logic signed [Q_W-1:0] s4_q [3];
  logic                  s4_hit_r, s4_hit_v, s4_eop;

  pvbc_axis_test #(.P_W(PROJ_W), .SHIFT(SHIFT_LIN)) u_test_right (
    .p        (s3_pr),
    .bounds   (bounds_right),
    .box_size (box_size),
    .hit      (hit_r)
  );

  pvbc_axis_test #(.P_W(PROJ_W), .SHIFT(SHIFT_LIN)) u_test_view (
    .p        (s3_pv),
    .bounds   (bounds_view),
    .box_size (box_size),
    .hit      (hit_v)
  );

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int k = 0; k < 3; k++) begin
        s4_q[k] <= s3_v[k] * s3_u[k];
      end
      s4_hit_r <= hit_r;
      s4_hit_v <= hit_v;
      s4_eop   <= s3_eop;
    end
  end

  // stage 5: up sum
  logic signed [PU_W-1:0] s5_pu;
  logic                   s5_hit_rv, s5_eop;

  always_ff @(posedge clk) begin
    if (advance) begin
      s5_pu     <= PU_W'(s4_q[0]) + PU_W'(s4_q[1]) + PU_W'(s4_q[2]);
      s5_hit_rv <= s4_hit_r && s4_hit_v;
      s5_eop    <= s4_eop;
    end
  end

  // stage 6: up bound test, fill sampling, counters
  logic hit_u;

  pvbc_axis_test #(.P_W(PU_W), .SHIFT(SHIFT_UP)) u_test_up (
    .p        (s5_pu),
    .bounds   (bounds_up),
    .box_size (box_size),
    .hit      (hit_u)
  );

  logic [INDEX_WIDTH-1:0] index_counter, index_counter_next;
  logic [INDEX_WIDTH-1:0] fill_phase, fill_phase_next;
  logic [INDEX_WIDTH:0]   kept_counter, kept_counter_next;
  logic [INDEX_WIDTH:0]   kept_step;
  logic [PH_W-1:0]        phase_inc;
  logic                   fill, keep_now;

  always_comb begin
    fill      = (fill_divisor != '0) && (fill_phase == '0);
    keep_now  = fill || (s5_hit_rv && hit_u);
    phase_inc = PH_W'(fill_phase) + PH_W'(1);
    kept_step = (keep_now && kept_counter != '1) ? kept_counter + 1'b1 : kept_counter;
    if (s5_eop) begin
      index_counter_next = '0;
      fill_phase_next    = '0;
      kept_counter_next  = '0;
    end else begin
      index_counter_next = index_counter + 1'b1;
      kept_counter_next  = kept_step;
      if (fill_divisor == '0 || phase_inc >= PH_W'(fill_divisor)) begin
        fill_phase_next = '0;
      end else begin
        fill_phase_next = phase_inc[INDEX_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      index_counter <= '0;
      fill_phase    <= '0;
      kept_counter  <= '0;
    end else if (advance && s5_valid) begin
      index_counter <= index_counter_next;
      fill_phase    <= fill_phase_next;
      kept_counter  <= kept_counter_next;
    end
  end

  logic                   out_keep;
  logic [INDEX_WIDTH-1:0] out_index;
  logic [INDEX_WIDTH:0]   out_kept;
  logic                   out_eop;

  always_ff @(posedge clk) begin
    if (advance) begin
      out_keep  <= keep_now;
      out_index <= index_counter;
      out_kept  <= kept_step;
      out_eop   <= s5_eop;
    end
  end

  assign result.valid          = out_valid;
  assign result.keep           = out_keep;
  assign result.particle_index = out_index;
  assign result.kept_count     = out_kept;

  logic                   out_beat;
  logic [INDEX_WIDTH-1:0] index_step;
  logic                   restart_ok;

  assign out_beat   = out_valid && result.ready;
  assign index_step = out_index + 1'b1;
  assign restart_ok = (out_index == '0) && (out_kept == {{INDEX_WIDTH{1'b0}}, out_keep});

  `PVBC_ASSERT_RESET(a_reset_empties, rst |=> !result.valid)
  `PVBC_ASSERT(a_keep_counted, result.valid && result.keep |-> result.kept_count != '0)
  `PVBC_ASSERT(a_index_steps, out_beat && !out_eop |=> out_index == $past(index_step))
  `PVBC_ASSERT(a_pass_restarts, out_beat && out_eop |=> !out_valid || restart_ok)

endmodule

// ===== hdl/pvbc_axis_test.sv =====
// ---------------------------------------------------------------------------
// Periodic axis bound test
// Tests a projection and its two periodic images against scaled bounds.
// ---------------------------------------------------------------------------
module pvbc_axis_test #(
  parameter int P_W   = 40,
  parameter int SHIFT = 14
) (
  input  logic signed [P_W-1:0]         p,
  input  pvbc_pkg::bounds_t             bounds,
  input  logic [pvbc_pkg::BOX_W-1:0]    box_size,
  output logic                          hit
);
  import pvbc_pkg::*;

  localparam int W = ((P_W > BOUND_W + SHIFT) ? P_W : BOUND_W + SHIFT) + 2;

  logic signed [W-1:0] p_x;
  logic signed [W-1:0] lo;
  logic signed [W-1:0] hi;
  logic signed [W-1:0] box;
  logic signed [W-1:0] p_m;
  logic signed [W-1:0] p_p;

  assign p_x = W'(p);
  assign lo  = W'($signed(bounds.lo)) <<< SHIFT;
  assign hi  = W'($signed(bounds.hi)) <<< SHIFT;
  assign box = W'({1'b0, box_size}) <<< SHIFT;
  assign p_m = p_x - box;
  assign p_p = p_x + box;

  assign hit = (p_x >= lo && p_x <= hi) ||
               (p_m >= lo && p_m <= hi) ||
               (p_p >= lo && p_p <= hi);

endmodule
